// ===== hw/rtl/wstd_pkg.sv =====
// ----------------------------------------------------------------------------
// wstd_pkg
// Shared sizes, codes and types of the work-stealing task deque.
// ----------------------------------------------------------------------------
package wstd_pkg;

   localparam int DEPTH       = 64;
   localparam int HANDLE_BITS = 32;
   localparam int IDX_BITS    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS    = $clog2(DEPTH + 1);

   localparam int REQ_BITS    = 2;
   localparam int TASK_BITS   = 32;
   localparam int STATUS_BITS = 2;
   localparam int OCC_BITS    = 7;

   typedef enum logic [REQ_BITS-1:0] {
      REQ_PUSH = 2'd0,
      REQ_POP  = 2'd1,
      REQ_TAKE = 2'd2
   } req_code_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // ring store access for one request
   typedef struct packed {
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_addr;
      logic                rd_en;
      logic [IDX_BITS-1:0] rd_addr;
   } store_cmd_type;

   function automatic logic [IDX_BITS-1:0] ring_next(input logic [IDX_BITS-1:0] i);
      return (i == IDX_BITS'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_BITS-1:0] ring_prev(input logic [IDX_BITS-1:0] i);
      return (i == '0) ? IDX_BITS'(DEPTH - 1) : i - 1'b1;
   endfunction

endpackage

// ===== hw/rtl/work_stealing_task_deque_top.sv =====
// ----------------------------------------------------------------------------
// work_stealing_task_deque_top
// Work-stealing task deque: push/pop at the top end, take from the base end.
// ----------------------------------------------------------------------------
// One request word is taken every cycle (busy stays low); its response
// appears on the rsp_ ports in the cycle after acceptance, for exactly one
// cycle, with rsp_valid high. The handle is read through the registered
// read port of the handle ring. The receiver cannot stall, so
// every response must be captured in the cycle it is shown. No clearing
// pass runs after reset: the deque is empty and ready at once.
module work_stealing_task_deque_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [wstd_pkg::REQ_BITS-1:0]        req_type,
   input  logic [wstd_pkg::TASK_BITS-1:0]       req_task_handle,
   output logic                                 rsp_valid,
   output logic [wstd_pkg::TASK_BITS-1:0]       rsp_task_out,
   output logic [wstd_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [wstd_pkg::OCC_BITS-1:0]        rsp_occupancy
);

   logic                                accept;
   wstd_pkg::store_cmd_type             cmd;
   logic                                rd_ok;
   wstd_pkg::status_type                status;
   logic [wstd_pkg::CNT_BITS-1:0]       count;
   logic [wstd_pkg::HANDLE_BITS-1:0]    rd_data;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   wstd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_code (req_type),
      .cmd      (cmd),
      .valid    (rsp_valid),
      .rd_ok    (rd_ok),
      .status   (status),
      .count    (count)
   );

   wstd_store u_store (
      .clock   (clock),
      .cmd     (cmd),
      .wr_data (wstd_pkg::HANDLE_BITS'(req_task_handle)),
      .rd_data (rd_data)
   );

   assign rsp_task_out  = rd_ok ? wstd_pkg::TASK_BITS'(rd_data) : '0;
   assign rsp_status    = status;
   assign rsp_occupancy = wstd_pkg::OCC_BITS'(count);

endmodule

// ===== hw/rtl/wstd_store.sv =====
// ----------------------------------------------------------------------------
// wstd_store
// Handle ring memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wstd_store (
   input  logic                                 clock,
   input  wstd_pkg::store_cmd_type              cmd,
   input  logic [wstd_pkg::HANDLE_BITS-1:0]     wr_data,
   output logic [wstd_pkg::HANDLE_BITS-1:0]     rd_data
);

   logic [wstd_pkg::HANDLE_BITS-1:0] mem_ff [wstd_pkg::DEPTH];
   logic [wstd_pkg::HANDLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[cmd.wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/wstd_ctrl.sv =====
// ----------------------------------------------------------------------------
// wstd_ctrl
// Top/base pointers, fill count and response status of the deque.
// ----------------------------------------------------------------------------
module wstd_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [wstd_pkg::REQ_BITS-1:0]        req_code,
   output wstd_pkg::store_cmd_type              cmd,
   output logic                                 valid,
   output logic                                 rd_ok,
   output wstd_pkg::status_type                 status,
   output logic [wstd_pkg::CNT_BITS-1:0]        count
);

   logic [wstd_pkg::IDX_BITS-1:0] top_ff, top_in;
   logic [wstd_pkg::IDX_BITS-1:0] base_ff, base_in;
   logic [wstd_pkg::CNT_BITS-1:0] count_ff, count_in;
   logic                          valid_ff, valid_in;
   logic                          rd_ok_ff, rd_ok_in;
   wstd_pkg::status_type          status_ff, status_in;

   logic is_full, is_empty;

   assign is_full  = (count_ff == wstd_pkg::CNT_BITS'(wstd_pkg::DEPTH));
   assign is_empty = (count_ff == '0);

   always_comb begin
      top_in       = top_ff;
      base_in      = base_ff;
      count_in     = count_ff;
      status_in    = wstd_pkg::ST_OK;
      rd_ok_in     = 1'b0;
      valid_in     = accept;
      cmd.wr_en    = 1'b0;
      cmd.wr_addr  = top_ff;
      cmd.rd_en    = 1'b0;
      cmd.rd_addr  = base_ff;
      if (accept) begin
         case (req_code)
            wstd_pkg::REQ_PUSH: begin
               if (is_full) begin
                  status_in = wstd_pkg::ST_FULL;
               end else begin
                  cmd.wr_en = 1'b1;
                  top_in    = wstd_pkg::ring_next(top_ff);
                  count_in  = count_ff + 1'b1;
               end
            end
            wstd_pkg::REQ_POP: begin
               if (is_empty) begin
                  status_in = wstd_pkg::ST_EMPTY;
               end else begin
                  top_in      = wstd_pkg::ring_prev(top_ff);
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = wstd_pkg::ring_prev(top_ff);
                  rd_ok_in    = 1'b1;
                  count_in    = count_ff - 1'b1;
               end
            end
            wstd_pkg::REQ_TAKE: begin
               if (is_empty) begin
                  status_in = wstd_pkg::ST_EMPTY;
               end else begin
                  base_in   = wstd_pkg::ring_next(base_ff);
                  cmd.rd_en = 1'b1;
                  rd_ok_in  = 1'b1;
                  count_in  = count_ff - 1'b1;
               end
            end
            default: begin
               // unused code: no state change, plain ok response
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff   <= '0;
         base_ff  <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         top_ff   <= top_in;
         base_ff  <= base_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         rd_ok_ff  <= rd_ok_in;
      end
   end

   assign valid  = valid_ff;
   assign rd_ok  = rd_ok_ff;
   assign status = status_ff;
   assign count  = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= wstd_pkg::CNT_BITS'(wstd_pkg::DEPTH))
      else $error("fill count above capacity");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> top_ff == base_ff)
      else $error("empty deque with unequal pointers");

   a_full_resp: assert property (@(posedge clock) disable iff (reset)
      valid_ff && status_ff == wstd_pkg::ST_FULL
         |-> count_ff == wstd_pkg::CNT_BITS'(wstd_pkg::DEPTH))
      else $error("full status without full count");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> valid_ff)
      else $error("accepted word without response");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not bump count");

endmodule
